FILE: design/lse_pkg.sv
// Shared constants, codes and types for the LSB stego extractor.
package lse_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int LEN_W       = LENGTH_BITS;
	localparam int HDR_CNT_W   = $clog2(LENGTH_BITS + 1);
	localparam int POS_W       = HDR_CNT_W + 1;
	localparam int DIM_W       = 15;
	localparam int PROD_W      = 2 * DIM_W;
	localparam int CAP_W       = PROD_W + 2;
	localparam int NEED_W      = LEN_W + 4;
	localparam int CMP_W       = (NEED_W > CAP_W) ? NEED_W : CAP_W;
	localparam int NUM_LANES   = 3;
	localparam int LANE_IDX_W  = $clog2(NUM_LANES);
	localparam int LANE_CNT_W  = $clog2(NUM_LANES + 1);
	localparam int OB_DEPTH    = 2;
	localparam int OB_PTR_W    = $clog2(OB_DEPTH);
	localparam int OB_CNT_W    = $clog2(OB_DEPTH + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3 * int'(DIM_RESET) * int'(DIM_RESET));

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DATA  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [1:0]           phase;
		logic [HDR_CNT_W-1:0] hdr_cnt;
		logic [LEN_W-1:0]     len;
		logic [7:0]           asm_byte;
		logic [2:0]           bit_cnt;
		logic [LEN_W-1:0]     rem;
	} state_t;

	typedef struct packed {
		logic lsb;
		logic hdr;
		logic hdr_end;
		logic dat;
		logic byte_end;
	} lane_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
		logic [1:0] status;
	} result_t;

endpackage

FILE: design/lse_lane.sv
// One extraction lane: classifies a single hidden bit of the pixel.
module lse_lane (
	input  lse_pkg::state_t                  st,
	input  logic [lse_pkg::LANE_IDX_W-1:0]   idx,
	input  logic                             bit_in,
	output lse_pkg::lane_t                   lane
);
	import lse_pkg::*;

	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] hdr_dpos;
	logic [2:0]       dat_pos;

	assign pos      = POS_W'(st.hdr_cnt) + POS_W'(idx);
	assign hdr_dpos = pos - POS_W'(LENGTH_BITS);
	assign dat_pos  = st.bit_cnt + 3'(idx);

	always_comb begin
		lane          = '0;
		lane.lsb      = bit_in;
		case (st.phase)
			PH_HEADER: begin
				lane.hdr      = pos < POS_W'(LENGTH_BITS);
				lane.hdr_end  = pos == POS_W'(LENGTH_BITS - 1);
				lane.dat      = !lane.hdr;
				lane.byte_end = !lane.hdr && (hdr_dpos[2:0] == 3'd7);
			end
			PH_DATA: begin
				lane.dat      = 1'b1;
				lane.byte_end = dat_pos == 3'd7;
			end
			default: begin
				lane.hdr      = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/lse_merge.sv
// Merge stage: folds the lane findings into the extraction state and result.
module lse_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    fire,
	input  logic                                    start,
	input  logic [lse_pkg::CAP_W-1:0]               cap,
	input  lse_pkg::lane_t [lse_pkg::NUM_LANES-1:0] lanes,
	output lse_pkg::state_t                         eff,
	output logic                                    res_valid,
	output lse_pkg::result_t                        res
);
	import lse_pkg::*;

	state_t state_q;
	state_t nxt;

	logic [LANE_CNT_W-1:0] nh;
	logic [NUM_LANES-1:0]  hdr_bits;
	logic [LEN_W-1:0]      len_next;
	logic [CMP_W-1:0]      need;
	logic                  hdr_done;
	logic                  len_zero;
	logic                  too_long;
	logic                  hdr_ok;
	logic [LEN_W-1:0]      rem_base;
	logic                  alive;
	logic                  byte_done;
	logic [7:0]            byte_val;
	logic [7:0]            asm_v;
	logic [2:0]            bit_v;

	always_comb begin
		eff = state_q;
		if (start) begin
			eff.phase    = PH_HEADER;
			eff.hdr_cnt  = '0;
			eff.len      = '0;
			eff.asm_byte = '0;
			eff.bit_cnt  = '0;
			eff.rem      = '0;
		end
	end

	always_comb begin
		nh       = '0;
		hdr_bits = '0;
		hdr_done = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			nh                        = nh + LANE_CNT_W'(lanes[i].hdr);
			hdr_bits[NUM_LANES-1-i]   = lanes[i].lsb & lanes[i].hdr;
			hdr_done                  = hdr_done | lanes[i].hdr_end;
		end
		len_next = (eff.len << nh)
			| LEN_W'(hdr_bits >> (LANE_CNT_W'(NUM_LANES) - nh));
		need     = CMP_W'({len_next, 3'b000}) + CMP_W'(LENGTH_BITS);
		len_zero = len_next == '0;
		too_long = need > CMP_W'(cap);
		hdr_ok   = !len_zero && !too_long;
		rem_base = hdr_done ? len_next : eff.rem;
	end

	always_comb begin
		alive     = eff.phase == PH_DATA;
		byte_done = 1'b0;
		byte_val  = '0;
		asm_v     = eff.asm_byte;
		bit_v     = eff.bit_cnt;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (alive && lanes[i].dat) begin
				asm_v = {asm_v[6:0], lanes[i].lsb};
				if (lanes[i].byte_end) begin
					byte_done = 1'b1;
					byte_val  = asm_v;
					asm_v     = '0;
					bit_v     = '0;
					alive     = rem_base != LEN_W'(1);
				end else begin
					bit_v = bit_v + 3'd1;
				end
			end
			if (lanes[i].hdr_end) begin
				alive = hdr_ok;
				asm_v = '0;
				bit_v = '0;
			end
		end
	end

	always_comb begin
		nxt          = eff;
		nxt.len      = len_next;
		nxt.hdr_cnt  = eff.hdr_cnt + HDR_CNT_W'(nh);
		nxt.asm_byte = asm_v;
		nxt.bit_cnt  = bit_v;
		nxt.rem      = byte_done ? rem_base - LEN_W'(1) : rem_base;
		if (hdr_done) begin
			nxt.phase = hdr_ok ? PH_DATA : PH_DONE;
		end
		if (byte_done && rem_base == LEN_W'(1)) begin
			nxt.phase = PH_DONE;
		end
	end

	always_comb begin
		res_valid        = fire && ((hdr_done && !hdr_ok) || byte_done);
		res.payload_byte = byte_done ? byte_val : 8'd0;
		res.last_byte    = byte_done && rem_base == LEN_W'(1);
		if (hdr_done && len_zero) begin
			res.status = ST_NO_DATA;
		end else if (hdr_done && too_long) begin
			res.status = ST_TOO_LONG;
		end else begin
			res.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			state_q.phase <= PH_HEADER;
		end else if (fire) begin
			state_q <= nxt;
		end
	end

endmodule

FILE: design/lse_outbuf.sv
// Two-entry result buffer between the merge stage and the output channel.
module lse_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lse_pkg::result_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output lse_pkg::result_t  out_data
);
	import lse_pkg::*;

	result_t               ent_q [OB_DEPTH];
	logic [OB_PTR_W-1:0]   wr_q;
	logic [OB_PTR_W-1:0]   rd_q;
	logic [OB_CNT_W-1:0]   cnt_q;
	logic                  pop;

	assign full      = cnt_q == OB_CNT_W'(OB_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OB_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OB_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + OB_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OB_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/lsb_stego_extractor_core.sv
// LSB stego extractor top level: config registers, lanes, merge and result buffer.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  start_of_image, pixel_blue/green/red
//  out      source     out_valid/out_stall  payload_byte, last_byte, status
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One pixel per clock while in_stall is low; three lanes take the blue, green and red bits together.
//  A result is registered in the result buffer at the edge that accepts its pixel.
//  The capacity register takes a new dimension at the edge of its write.
//  Reset puts extraction in the header phase with both dimensions at 512.
//  in_stall rises only when both entries of the result buffer are full.
module lsb_stego_extractor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_of_image,
	input  logic [7:0]                        pixel_blue,
	input  logic [7:0]                        pixel_green,
	input  logic [7:0]                        pixel_red,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        payload_byte,
	output logic                              last_byte,
	output logic [1:0]                        status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lse_pkg::DIM_W-1:0]         cfg_data
);
	import lse_pkg::*;

	logic [DIM_W-1:0]           width_q;
	logic [DIM_W-1:0]           height_q;
	logic [DIM_W-1:0]           mul_a;
	logic [DIM_W-1:0]           mul_b;
	logic [PROD_W-1:0]          prod;
	logic [CAP_W-1:0]           cap_q;
	logic                       fire;
	logic [NUM_LANES-1:0]       lsb_vec;
	state_t                     eff;
	lane_t [NUM_LANES-1:0]      lanes;
	logic                       res_valid;
	result_t                    res;
	result_t                    out_data;

	assign cfg_ready = 1'b1;
	assign fire      = in_valid && !in_stall;
	assign lsb_vec   = {pixel_red[0], pixel_green[0], pixel_blue[0]};

	always_comb begin
		mul_a = width_q;
		mul_b = height_q;
		if (cfg_index == CFG_IMAGE_WIDTH) begin
			mul_a = cfg_data;
		end else begin
			mul_b = cfg_data;
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			cap_q    <= CAP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default:          width_q  <= width_q;
				endcase
				cap_q <= CAP_W'(prod) + CAP_W'({prod, 1'b0});
			end
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		lse_lane u_lane (
			.st     (eff),
			.idx    (LANE_IDX_W'(i)),
			.bit_in (lsb_vec[i]),
			.lane   (lanes[i])
		);
	end

	lse_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.start     (start_of_image),
		.cap       (cap_q),
		.lanes     (lanes),
		.eff       (eff),
		.res_valid (res_valid),
		.res       (res)
	);

	lse_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign payload_byte = out_data.payload_byte;
	assign last_byte    = out_data.last_byte;
	assign status       = out_data.status;

`ifndef SYNTH
	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("result buffer full with no output request");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_byte == 8'd0 && !last_byte)
		else $error("error result carries payload");

	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && start_of_image |-> !res_valid)
		else $error("result produced on a start-of-image pixel");

	a_no_result_without_request: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> !res_valid)
		else $error("result produced with no accepted request");
`endif

endmodule

FILE: sim/lsb_stego_extractor_core_tb.sv
// Self-checking testbench for lsb_stego_extractor_core: images of hidden payloads, checked per result.
`timescale 1ns / 100ps

module lsb_stego_extractor_core_tb;
	import lse_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_of_image = 1'b0;
	logic [7:0] pixel_blue = 8'h00;
	logic [7:0] pixel_green = 8'h00;
	logic [7:0] pixel_red = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic last_byte;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [DIM_W-1:0] cfg_data = '0;

	lsb_stego_extractor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_of_image(start_of_image),
		.pixel_blue(pixel_blue),
		.pixel_green(pixel_green),
		.pixel_red(pixel_red),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// extraction state of the predictor
	logic [DIM_W-1:0] dim_w = DIM_RESET;
	logic [DIM_W-1:0] dim_h = DIM_RESET;
	logic [1:0] ex_phase = PH_HEADER;
	logic [5:0] ex_hdr_cnt = '0;
	logic [LEN_W-1:0] ex_len = '0;
	logic [7:0] ex_byte = '0;
	logic [2:0] ex_bit_cnt = '0;
	logic [LEN_W-1:0] ex_left = '0;

	result_t predicted_out[$];

	int in_idle_pct = 30;
	int out_idle_pct = 30;
	int live_pixels = 0;
	int dim_settings = 0;
	int errors = 0;
	int n_ok = 0;
	int n_no_data = 0;
	int n_too_long = 0;
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				predicted_out.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < out_idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_out.size() == 0) begin
				$error("unexpected result: payload_byte %02h last_byte %0b status %0d",
					payload_byte, last_byte, status);
				errors++;
			end else begin
				want = predicted_out.pop_front();
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h", want.payload_byte,
						payload_byte);
					errors++;
				end
				if (last_byte !== want.last_byte) begin
					$error("last_byte: expected %0b, got %0b", want.last_byte, last_byte);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				case (want.status)
					ST_OK: n_ok++;
					ST_NO_DATA: n_no_data++;
					default: n_too_long++;
				endcase
			end
		end
	end

	task automatic extract_bit(input logic b);
		result_t r;
		logic [63:0] cap;
		logic [63:0] need;
		case (ex_phase)
			PH_HEADER: begin
				ex_len = {ex_len[LEN_W-2:0], b};
				ex_hdr_cnt = ex_hdr_cnt + 6'd1;
				if (ex_hdr_cnt == 6'(LENGTH_BITS)) begin
					cap = 64'(dim_w) * 64'(dim_h) * 64'd3;
					need = 64'(LENGTH_BITS) + 64'(ex_len) * 64'd8;
					r.payload_byte = 8'h00;
					r.last_byte = 1'b0;
					if (ex_len == '0) begin
						ex_phase = PH_DONE;
						r.status = ST_NO_DATA;
						predicted_out.push_back(r);
					end else if (need > cap) begin
						ex_phase = PH_DONE;
						r.status = ST_TOO_LONG;
						predicted_out.push_back(r);
					end else begin
						ex_phase = PH_DATA;
						ex_left = ex_len;
						ex_byte = '0;
						ex_bit_cnt = '0;
					end
				end
			end
			PH_DATA: begin
				ex_byte = {ex_byte[6:0], b};
				if (ex_bit_cnt == 3'd7) begin
					r.payload_byte = ex_byte;
					r.last_byte = (ex_left == 1);
					r.status = ST_OK;
					predicted_out.push_back(r);
					ex_bit_cnt = '0;
					ex_byte = '0;
					ex_left = ex_left - 1;
					if (ex_left == '0)
						ex_phase = PH_DONE;
				end else begin
					ex_bit_cnt = ex_bit_cnt + 3'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic extract_pixel(input logic sof, input logic [2:0] lsbs);
		if (sof) begin
			ex_phase = PH_HEADER;
			ex_hdr_cnt = '0;
			ex_len = '0;
			ex_byte = '0;
			ex_bit_cnt = '0;
			ex_left = '0;
		end
		extract_bit(lsbs[2]);
		extract_bit(lsbs[1]);
		extract_bit(lsbs[0]);
	endtask

	// lsbs[2] rides on blue, lsbs[1] on green, lsbs[0] on red
	task automatic send_pixel(input logic sof, input logic [2:0] lsbs, input logic solid);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			start_of_image = 1'($urandom);
			pixel_blue = 8'($urandom);
			pixel_green = 8'($urandom);
			pixel_red = 8'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		start_of_image = sof;
		pixel_blue = solid ? {8{lsbs[2]}} : {7'($urandom), lsbs[2]};
		pixel_green = solid ? {8{lsbs[1]}} : {7'($urandom), lsbs[1]};
		pixel_red = solid ? {8{lsbs[0]}} : {7'($urandom), lsbs[0]};
		do @(posedge clk); while (in_stall);
		if (sof || ex_phase == PH_HEADER || ex_phase == PH_DATA)
			live_pixels++;
		extract_pixel(sof, lsbs);
	endtask

	// header of len, then n_bytes data bytes, padded to whole pixels, then tail extra pixels
	task automatic send_image(input logic sof_first, input logic [31:0] len, input int n_bytes,
			input int tail, input logic solid);
		logic hidden[$];
		logic [7:0] d;
		logic [2:0] trio;
		logic first_px;
		int i;
		int j;
		for (i = 31; i >= 0; i--)
			hidden.push_back(len[i]);
		for (i = 0; i < n_bytes; i++) begin
			d = solid ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
			for (j = 7; j >= 0; j--)
				hidden.push_back(d[j]);
		end
		while (hidden.size() % 3 != 0)
			hidden.push_back(1'($urandom));
		first_px = sof_first;
		while (hidden.size() != 0) begin
			trio[2] = hidden.pop_front();
			trio[1] = hidden.pop_front();
			trio[0] = hidden.pop_front();
			send_pixel(first_px, trio, solid);
			first_px = 1'b0;
		end
		repeat (tail) send_pixel(1'b0, 3'($urandom), solid);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (predicted_out.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IMAGE_WIDTH)
			dim_w = value;
		else
			dim_h = value;
	endtask

	task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		wait_drained();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_valid = 1'b0;
		dim_settings++;
		// hold off until the capacity product settles
		repeat (4) @(posedge clk);
	endtask

	task automatic test_no_start_flag();
		send_image(1'b0, 32'd2, 2, 2, 1'b1);
	endtask

	task automatic test_restart_mid_image();
		send_image(1'b1, 32'd5, 2, 0, 1'b0);
		send_image(1'b1, 32'd1, 1, 3, 1'b0);
	endtask

	task automatic test_zero_length();
		send_image(1'b1, 32'd0, 0, 2, 1'b1);
	endtask

	task automatic test_capacity_edges();
		write_dims(15'd4, 15'd4);
		send_image(1'b1, 32'd2, 2, 1, 1'b0);
		send_image(1'b1, 32'd3, 0, 1, 1'b0);
		write_dims(15'd32767, 15'd32767);
		send_image(1'b1, 32'd402628604, 1, 0, 1'b0);
		send_image(1'b1, 32'd402628605, 0, 0, 1'b0);
		send_image(1'b1, 32'hFFFF_FFFF, 0, 1, 1'b1);
		write_dims(15'd16384, 15'd16384);
		send_image(1'b1, 32'd100663292, 1, 0, 1'b0);
		send_image(1'b1, 32'd100663293, 0, 0, 1'b0);
		write_dims(15'd0, 15'd32767);
		send_image(1'b1, 32'd1, 0, 1, 1'b0);
		send_image(1'b1, 32'd0, 0, 0, 1'b0);
	endtask

	task automatic test_random_images(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input int target, input int idle_pct);
		logic [63:0] cap;
		logic [63:0] lmax;
		logic [31:0] len;
		int lim;
		int kind;
		int base;
		write_dims(w, h);
		in_idle_pct = idle_pct;
		out_idle_pct = idle_pct;
		cap = 64'(w) * 64'(h) * 64'd3;
		lmax = (cap < 32) ? 64'd0 : (cap - 64'd32) / 64'd8;
		base = live_pixels;
		while (live_pixels - base < target) begin
			kind = $urandom_range(99);
			if (kind < 60 && lmax != 0) begin
				lim = (lmax > 6) ? 6 : int'(lmax);
				len = $urandom_range(lim, 1);
				send_image(1'b1, len, int'(len), $urandom_range(2), 1'b0);
			end else if (kind < 68) begin
				send_image(1'b1, 32'd0, 0, $urandom_range(2), 1'b0);
			end else if (kind < 80) begin
				len = 32'(lmax + 64'd1 + 64'($urandom_range(3)));
				send_image(1'b1, len, 0, $urandom_range(2), 1'b0);
			end else if (kind < 87) begin
				send_image(1'b1, $urandom, $urandom_range(3), 0, 1'b0);
			end else if (kind < 94 && lmax >= 2) begin
				lim = (lmax > 40) ? 40 : int'(lmax);
				len = $urandom_range(lim, 2);
				send_image(1'b1, len, $urandom_range(int'(len) - 1), 0, 1'b0);
			end else begin
				repeat ($urandom_range(6, 1))
					send_pixel($urandom_range(9) == 0, 3'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_no_start_flag();
		test_restart_mid_image();
		test_zero_length();
		test_capacity_edges();
		test_random_images(15'd16384, 15'd16384, 300, 30);
		test_random_images(15'd3, 15'd5, 150, 30);
		test_random_images(15'd100, 15'd7, 200, 0);
		test_random_images(15'd1, 15'd1, 100, 30);
		test_random_images(15'd2, 15'd20, 100, 30);
		test_random_images(15'd32767, 15'd0, 100, 30);
		wait_drained();
		$display("%0d live pixels over %0d dimension settings; %0d bytes, %0d empty headers,",
			live_pixels, dim_settings, n_ok, n_no_data);
		$display("%0d oversize headers checked, %0d mismatches", n_too_long, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
